### hw/rtl/swmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swmm_pkg;

	localparam int DATA_W         = 8;
	localparam int LEN_W          = 7;
	localparam int MAX_WINDOW_DEF = 64;
	localparam int LEN_RESET      = 64;

	// commands from the controller to the datapath, at most one per cycle
	typedef struct packed {
		logic load_len;  // take new length, restart from an empty window
		logic clr_wr;    // zero one store entry of the clearing pass
		logic take;      // latch the input word, read the entry to overwrite
		logic update;    // write the sample, advance the position, fold it in
		logic scan_rd;   // read one entry of the rescan
		logic apply;     // copy rescan results into the flagged limits
		logic publish;   // load the output register
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic clr_last;     // clearing pass at its last entry
		logic scan_last;    // rescan at its last entry
		logic need_rescan;  // overwritten entry equals a running limit
	} sts_t;

endpackage

`default_nettype wire

### hw/rtl/swmm_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module swmm_dpath #(
	parameter int MAX_WINDOW = swmm_pkg::MAX_WINDOW_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire swmm_pkg::cmd_t               cmd,
	output swmm_pkg::sts_t                    sts,
	input  wire logic [swmm_pkg::LEN_W-1:0]   cfg_len,
	input  wire logic [swmm_pkg::DATA_W-1:0]  sample,
	output logic      [swmm_pkg::DATA_W-1:0]  window_min,
	output logic      [swmm_pkg::DATA_W-1:0]  window_max
);

	localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
	localparam int RST_LEN = (swmm_pkg::LEN_RESET > MAX_WINDOW) ? MAX_WINDOW
	                                                            : swmm_pkg::LEN_RESET;

	logic [swmm_pkg::DATA_W-1:0] mem [MAX_WINDOW];
	logic [swmm_pkg::DATA_W-1:0] rd_q;
	logic [swmm_pkg::DATA_W-1:0] sample_q;
	logic [swmm_pkg::DATA_W-1:0] max_q, min_q;
	logic [swmm_pkg::DATA_W-1:0] acc_max_q, acc_min_q;
	logic [swmm_pkg::DATA_W-1:0] out_min_q, out_max_q;
	logic [CNT_W-1:0]            len_q;
	logic [IDX_W-1:0]            pos_q, cnt_q;
	logic                        rmax_q, rmin_q, acc_first_q, scan_vld_s1;

	logic [CNT_W-1:0]            new_len;
	logic                        rd_en, wr_en;
	logic [IDX_W-1:0]            rd_addr, wr_addr;
	logic [swmm_pkg::DATA_W-1:0] wr_data;
	logic                        hit_max, hit_min;
	logic                        pos_wrap;

	// length clamp: zero counts as one, saturate at the store depth
	always_comb begin
		if (cfg_len == '0) begin
			new_len = CNT_W'(1);
		end else if (32'(cfg_len) > 32'(MAX_WINDOW)) begin
			new_len = CNT_W'(MAX_WINDOW);
		end else begin
			new_len = CNT_W'(cfg_len);
		end
	end

	assign hit_max  = (rd_q == max_q);
	assign hit_min  = (rd_q == min_q);
	assign pos_wrap = (CNT_W'(pos_q) + CNT_W'(1)) >= len_q;

	assign sts.clr_last    = (CNT_W'(cnt_q) == len_q - CNT_W'(1));
	assign sts.scan_last   = (CNT_W'(cnt_q) == len_q - CNT_W'(1));
	assign sts.need_rescan = hit_max || hit_min;

	assign rd_en   = cmd.take || cmd.scan_rd;
	assign rd_addr = cmd.take ? pos_q : cnt_q;
	assign wr_en   = cmd.clr_wr || cmd.update;
	assign wr_addr = cmd.update ? pos_q : cnt_q;
	assign wr_data = cmd.update ? sample_q : '0;

	// single-port store, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= CNT_W'(RST_LEN);
			pos_q       <= '0;
			cnt_q       <= '0;
			max_q       <= '0;
			min_q       <= '0;
			rmax_q      <= 1'b0;
			rmin_q      <= 1'b0;
			acc_first_q <= 1'b1;
			scan_vld_s1 <= 1'b0;
		end else begin
			scan_vld_s1 <= cmd.scan_rd;
			if (cmd.load_len) begin
				len_q <= new_len;
				pos_q <= '0;
				cnt_q <= '0;
				max_q <= '0;
				min_q <= '0;
			end
			if (cmd.clr_wr || cmd.scan_rd) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end
			if (cmd.update) begin
				pos_q       <= pos_wrap ? '0 : pos_q + IDX_W'(1);
				cnt_q       <= '0;
				rmax_q      <= hit_max;
				rmin_q      <= hit_min;
				acc_first_q <= 1'b1;
				if (!hit_max && (sample_q > max_q)) begin
					max_q <= sample_q;
				end
				if (!hit_min && (sample_q < min_q)) begin
					min_q <= sample_q;
				end
			end
			// rescan accumulation, one entry per cycle behind the read
			if (scan_vld_s1) begin
				acc_first_q <= 1'b0;
				if (acc_first_q || (rd_q > acc_max_q)) begin
					acc_max_q <= rd_q;
				end
				if (acc_first_q || (rd_q < acc_min_q)) begin
					acc_min_q <= rd_q;
				end
			end
			if (cmd.apply) begin
				if (rmax_q) begin
					max_q <= acc_max_q;
				end
				if (rmin_q) begin
					min_q <= acc_min_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			sample_q <= sample;
		end
		if (cmd.publish) begin
			out_min_q <= min_q;
			out_max_q <= max_q;
		end
	end

	assign window_min = out_min_q;
	assign window_max = out_max_q;

endmodule

`default_nettype wire

### hw/rtl/swmm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module swmm_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_wr_en,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	output swmm_pkg::cmd_t      cmd,
	input  wire swmm_pkg::sts_t sts
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE,
		ST_SCAN,
		ST_DRAIN,
		ST_APPLY,
		ST_PUBLISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign out_free  = !out_valid_q || out_ready;
	// a length write restarts the block, so no word is taken in that cycle
	assign in_ready  = (state_q == ST_IDLE) && !cfg_wr_en;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		if (cfg_wr_en) begin
			cmd.load_len = 1'b1;
		end else begin
			unique case (state_q)
				ST_CLEAR:   cmd.clr_wr  = 1'b1;
				ST_IDLE:    cmd.take    = accept;
				ST_UPDATE:  cmd.update  = 1'b1;
				ST_SCAN:    cmd.scan_rd = 1'b1;
				ST_DRAIN:   cmd         = '0;
				ST_APPLY:   cmd.apply   = 1'b1;
				ST_PUBLISH: cmd.publish = out_free;
				default:    cmd         = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				state_q <= ST_CLEAR;
			end else begin
				unique case (state_q)
					ST_CLEAR: begin
						if (sts.clr_last) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (accept) begin
							state_q <= ST_UPDATE;
						end
					end
					ST_UPDATE: begin
						state_q <= sts.need_rescan ? ST_SCAN : ST_PUBLISH;
					end
					ST_SCAN: begin
						if (sts.scan_last) begin
							state_q <= ST_DRAIN;
						end
					end
					ST_DRAIN: state_q <= ST_APPLY;
					ST_APPLY: state_q <= ST_PUBLISH;
					ST_PUBLISH: begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end
					default: state_q <= ST_CLEAR;
				endcase
			end
		end
	end

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command in a cycle");

	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!out_valid_q || out_ready))
		else $error("output register loaded while a word waits");

	a_accept_update: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg_wr_en) |=> (state_q == ST_UPDATE))
		else $error("accepted word not followed by update");

	a_valid_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.publish))
		else $error("output valid without a publish");

endmodule

`default_nettype wire

### hw/rtl/sliding_window_min_max.sv
// Sliding-window minimum and maximum over unsigned 8-bit samples. Each input
// word overwrites the oldest entry of a ring of window_length entries and
// yields one output word with the smallest and largest value in the window;
// the store and both limits start at zero, so early results include zeros.
// Timing: a word whose overwritten entry matches neither limit passes through
// accept, update and publish, and the output is registered at publish; when it
// matches a limit the window is rescanned one entry per cycle through the
// single-port store after update, then drain and apply come before publish.
// The next word is accepted once the result sits in the output register,
// even if it has not been taken. After reset and after every window_length
// write a clearing pass zeroes the store, one entry per cycle over
// window_length entries (64 after reset), during which no word is accepted.
// window_length is to be written by the user only while the block is idle;
// the block does not enforce it. No word is accepted in the cycle of the write.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_min_max #(
	parameter int MAX_WINDOW = swmm_pkg::MAX_WINDOW_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// window length register, 0 reads as 1, above MAX_WINDOW saturates
	input  wire logic                         cfg_wr_en,
	input  wire logic [swmm_pkg::LEN_W-1:0]   cfg_wr_data,
	// input words
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [7:0]                   s_axis_tdata,   // [7:0] sample
	// result words
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output logic      [15:0]                  m_axis_tdata    // [7:0] window_min, [15:8] window_max
);

	swmm_pkg::cmd_t cmd;
	swmm_pkg::sts_t sts;

	logic [swmm_pkg::DATA_W-1:0] window_min;
	logic [swmm_pkg::DATA_W-1:0] window_max;

	// sequencing: clearing pass, update, rescan, output handshake
	swmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// sample store, write position, running limits, output register
	swmm_dpath #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_len    (cfg_wr_data),
		.sample     (s_axis_tdata[swmm_pkg::DATA_W-1:0]),
		.window_min (window_min),
		.window_max (window_max)
	);

	assign m_axis_tdata = {window_max, window_min};

endmodule

`default_nettype wire

### tb/swmm_window_checker.sv
`timescale 1ns / 1ps

module swmm_window_checker #(
	parameter int MAX_WINDOW = swmm_pkg::MAX_WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [swmm_pkg::LEN_W-1:0] cfg_wr_data,
	input  logic                       s_axis_tvalid,
	input  logic                       s_axis_tready,
	input  logic [7:0]                 s_axis_tdata,
	input  logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	input  logic [15:0]                m_axis_tdata,
	output int                         pending,
	output int                         errors
);

	// same layout as m_axis_tdata: min in the low byte
	typedef struct packed {
		logic [7:0] hi;
		logic [7:0] lo;
	} limits_t;

	logic [7:0]  ring [MAX_WINDOW];
	int unsigned ring_len;
	int unsigned wr_pos;
	logic [7:0]  run_max;
	logic [7:0]  run_min;
	limits_t     limits_due [$];
	limits_t     want;
	limits_t     got;
	int          bad = 0;

	assign errors = bad;

	function automatic int unsigned clamp_len(input int unsigned v);
		if (v == 0)
			return 1;
		if (v > MAX_WINDOW)
			return MAX_WINDOW;
		return v;
	endfunction

	task automatic clear_ring();
		foreach (ring[i])
			ring[i] = '0;
		wr_pos  = 0;
		run_max = '0;
		run_min = '0;
	endtask

	// overwrite the oldest entry and bring both limits up to date
	function automatic limits_t fold_sample(input logic [7:0] s);
		int unsigned pos;
		logic [7:0]  old;
		logic [7:0]  scan_hi;
		logic [7:0]  scan_lo;
		logic        redo_hi;
		logic        redo_lo;
		limits_t     r;
		pos = wr_pos;
		if (pos >= ring_len)
			pos = 0;
		old       = ring[pos];
		redo_hi   = (old == run_max);
		redo_lo   = (old == run_min);
		ring[pos] = s;
		scan_hi   = ring[0];
		scan_lo   = ring[0];
		for (int i = 1; i < ring_len; i++) begin
			if (ring[i] > scan_hi)
				scan_hi = ring[i];
			if (ring[i] < scan_lo)
				scan_lo = ring[i];
		end
		if (redo_hi)
			run_max = scan_hi;
		else if (s > run_max)
			run_max = s;
		if (redo_lo)
			run_min = scan_lo;
		else if (s < run_min)
			run_min = s;
		pos++;
		if (pos >= ring_len)
			pos = 0;
		wr_pos = pos;
		r.lo   = run_min;
		r.hi   = run_max;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_ring();
			ring_len = clamp_len(swmm_pkg::LEN_RESET);
			limits_due.delete();
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (limits_due.size() == 0) begin
					bad++;
					$display("%0t: unexpected result word, expected none, got min %0d max %0d",
						$time, got.lo, got.hi);
				end else begin
					want = limits_due.pop_front();
					if (got.lo !== want.lo) begin
						bad++;
						$display("%0t: window_min expected %0d, got %0d",
							$time, want.lo, got.lo);
					end
					if (got.hi !== want.hi) begin
						bad++;
						$display("%0t: window_max expected %0d, got %0d",
							$time, want.hi, got.hi);
					end
				end
			end
			if (cfg_wr_en) begin
				ring_len = clamp_len(cfg_wr_data);
				clear_ring();
			end
			if (s_axis_tvalid && s_axis_tready)
				limits_due.push_back(fold_sample(s_axis_tdata));
			pending <= limits_due.size();
		end
	end

endmodule

### tb/sliding_window_min_max_tb.sv
`timescale 1ns / 1ps

module sliding_window_min_max_tb;

	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int IDLE_PCT     = 36;     // idle cycles per hundred on each side
	localparam int SETTLE       = 8;      // quiet cycles before a length write and at the end
	localparam int RANDOM_WORDS = 1700;

	// sample patterns for the random phases
	typedef enum int {
		PAT_ANY,     // full byte range
		PAT_NARROW,  // a few neighboring values, so limits get overwritten often
		PAT_RAILS,   // only 0 and 255
		PAT_RISE,    // ramp up, wrapping at 255
		PAT_FALL     // ramp down, wrapping at 0
	} pattern_t;

	logic                       clk           = 1'b0;
	logic                       arst_n        = 1'b0;
	logic                       cfg_wr_en     = 1'b0;
	logic [swmm_pkg::LEN_W-1:0] cfg_wr_data   = '0;
	logic                       s_axis_tvalid = 1'b0;
	logic [7:0]                 s_axis_tdata  = '0;    // [7:0] sample
	logic                       m_axis_tready = 1'b0;
	wire                        s_axis_tready;
	wire                        m_axis_tvalid;
	wire  [15:0]                m_axis_tdata;          // [7:0] window_min, [15:8] window_max

	int pending;      // result words still owed by the block
	int errors;
	int cycles = 0;
	int sent   = 0;   // words accepted so far
	bit steady = 1'b0; // both sides run without idling while set

	sliding_window_min_max uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// watches all three ports, predicts each result word and compares
	swmm_window_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.pending       (pending),
		.errors        (errors)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver backpressure, random except in the steady stretch
	always @(posedge clk) begin
		m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// offer one word, with random idle cycles ahead of it, and hold it until taken;
	// returns on the edge that accepted it
	task automatic send_sample(input logic [7:0] s);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= s;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent++;
	endtask

	// stop sending and wait for every owed result word, then let the block settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// new window length, written only with the block idle
	task automatic write_len(input logic [swmm_pkg::LEN_W-1:0] v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	function automatic logic [7:0] next_sample(input pattern_t pat, input logic [7:0] base,
		input int k);
		case (pat)
			PAT_NARROW: return base + 8'($urandom_range(0, 3));
			PAT_RAILS:  return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			PAT_RISE:   return base + 8'(k);
			PAT_FALL:   return base - 8'(k);
			default:    return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		int          phase;
		int          n;
		int          r;
		int unsigned len_code;
		pattern_t    pat;
		logic [7:0]  base;

		phase = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset length of 64: the zeros after reset match both limits,
		// so the first words force rescans
		send_sample(8'd0);
		send_sample(8'd255);
		send_sample(8'd128);
		send_sample(8'd1);

		// window of one: every word overwrites the single entry and wraps
		write_len(7'd1);
		send_sample(8'd255);
		send_sample(8'd0);
		send_sample(8'd7);
		send_sample(8'd7);

		// zero length behaves as one
		write_len(7'd0);
		send_sample(8'd200);
		send_sample(8'd3);

		// all ones saturates to the largest window
		write_len(7'd127);
		send_sample(8'd9);

		// window of two: limits leave the window and get rescanned
		write_len(7'd2);
		send_sample(8'd10);
		send_sample(8'd250);
		send_sample(8'd10);
		send_sample(8'd250);
		send_sample(8'd5);

		// just past the largest window
		write_len(7'd65);
		send_sample(8'd255);
		send_sample(8'd255);

		// window of three with both rails in it
		write_len(7'd3);
		send_sample(8'd0);
		send_sample(8'd255);
		send_sample(8'd128);
		send_sample(8'd64);
		send_sample(8'd32);

		// random phases: a new length, a pattern and a run of words each;
		// mostly short windows since rescans of long ones are slow
		while (sent < 25 + RANDOM_WORDS) begin
			phase++;
			r = $urandom_range(0, 99);
			if (r < 8)
				len_code = 64;
			else if (r < 12)
				len_code = $urandom_range(65, 127);
			else if (r < 16)
				len_code = 0;
			else if (r < 22)
				len_code = $urandom_range(17, 63);
			else
				len_code = $urandom_range(1, 16);
			write_len(swmm_pkg::LEN_W'(len_code));
			steady <= (phase >= 6 && phase <= 8);
			n    = (len_code > 16) ? $urandom_range(20, 60) : $urandom_range(10, 80);
			pat  = pattern_t'($urandom_range(0, 4));
			base = 8'($urandom_range(0, 255));
			for (int k = 0; k < n; k++) begin
				// one pause mid-run until all owed results are back
				if (phase == 2 && k == n / 2)
					drain();
				send_sample(next_sample(pat, base, k));
			end
		end

		drain();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
